[rtl/rbsi_pkg.sv]
package rbsi_pkg;

	// Default coordinate format: signed Q16.16.
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Face normal component codes.
	localparam logic [1:0] NRM_NONE = 2'b00;
	localparam logic [1:0] NRM_POS  = 2'b01;
	localparam logic [1:0] NRM_NEG  = 2'b11;

endpackage

[rtl/ray_box_slab_intersect_core.sv]
// Ray segment versus axis-aligned box test, slab method.
// The slave channel takes one beat per ray/box pair: origin, displacement and
// the two box corners, twelve signed fixed-point coordinates packed in tdata.
// The master channel returns one beat per pair: tuser carries the hit flag,
// tdata the entry time, the face normal and the hit point. On a miss the
// entry time is 1.0 and the normal and point are zero.
// An input beat passes the divider registers, then the slab time, decision,
// product and output registers (default format signed Q16.16). While the
// receiver takes each output beat, one beat is accepted in every cycle: the
// six slab divisions run as restoring dividers unrolled into one quotient bit
// per pipeline stage, so throughput is one pair per clock whatever the data.
// The pipeline advances as a whole: when the output register holds a beat
// that the receiver does not take, every stage holds and s_axis_tready is
// low; nothing is dropped or repeated. Reset clears all valid bits, so the
// block comes out of reset empty and ready.
module ray_box_slab_intersect_core #(
	parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF,
	localparam int IN_W  = ((12 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_RAW = FRAC_BITS + 1 + 6 + 3 * COORD_WIDTH,
	localparam int OUT_W = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// entry_time, normal_x, normal_y, normal_z, point_x, point_y, point_z
	output logic [OUT_W-1:0] m_axis_tdata,
	// hit
	output logic             m_axis_tuser
);
	import rbsi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int TW = F + 3;
	localparam int ND = F + 2;
	localparam logic signed [TW-1:0] TLIM = TW'(2) <<< F;
	localparam logic signed [TW-1:0] ONE  = TW'(1) <<< F;

	typedef struct packed {
		logic         neg;
		logic         sat;
		logic [W-1:0] r;
		logic [W-1:0] b;
		logic [F:0]   q;
	} dv_t;

	typedef struct packed {
		dv_t [5:0]          dv;
		logic [2:0][W-1:0]  org;
		logic [2:0][W-1:0]  dir;
		logic [2:0]         dz;
		logic               ok;
	} ds_t;

	typedef struct packed {
		logic [2:0][TW-1:0] ent;
		logic [2:0][TW-1:0] ext;
		logic [2:0][W-1:0]  org;
		logic [2:0][W-1:0]  dir;
		logic               ok;
	} ts_t;

	typedef struct packed {
		logic               hit;
		logic [F:0]         tin;
		logic [1:0]         axis;
		logic [2:0][W-1:0]  org;
		logic [2:0][W-1:0]  dir;
	} rs_t;

	typedef struct packed {
		logic               hit;
		logic [F:0]         tin;
		logic [2:0][1:0]    nrm;
		logic [2:0][W:0]    prod;
		logic [2:0]         dneg;
		logic [2:0][W-1:0]  org;
	} ms_t;

	// Pipeline registers.
	ds_t             div_s [ND];
	logic [ND-1:0]   div_vld_s;
	ts_t             t_s;
	logic            t_vld_s;
	rs_t             r_s;
	logic            r_vld_s;
	ms_t             m_s;
	logic            m_vld_s;
	logic            out_vld_q;
	logic            hit_q;
	logic [F:0]      tin_q;
	logic [2:0][1:0] nrm_q;
	logic [2:0][W-1:0] pnt_q;

	ds_t  div_d [ND];
	ts_t  t_d;
	rs_t  r_d;
	ms_t  m_d;
	logic [2:0][W-1:0] pnt_d;
	logic ce;

	// The whole pipeline moves unless a finished beat waits at the output.
	assign ce            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = ce;

	// Input stage: slab numerators and their magnitudes, zero-direction checks.
	always_comb begin
		logic signed [W-1:0] o, d, lo, hi;
		logic signed [W:0]   nlo, nhi, dw;
		logic [W:0]          alo, ahi, ad;
		div_d[0] = '0;
		div_d[0].ok = 1'b1;
		for (int k = 0; k < 3; k++) begin
			o  = s_axis_tdata[k*W +: W];
			d  = s_axis_tdata[(3+k)*W +: W];
			lo = s_axis_tdata[(6+k)*W +: W];
			hi = s_axis_tdata[(9+k)*W +: W];
			nlo = {lo[W-1], lo} - {o[W-1], o};
			nhi = {hi[W-1], hi} - {o[W-1], o};
			dw  = {d[W-1], d};
			alo = nlo[W] ? -nlo : nlo;
			ahi = nhi[W] ? -nhi : nhi;
			ad  = dw[W] ? -dw : dw;
			div_d[0].org[k] = o;
			div_d[0].dir[k] = d;
			div_d[0].dz[k]  = (d == '0);
			if (d == '0 && !(lo <= o && o <= hi))
				div_d[0].ok = 1'b0;
			div_d[0].dv[2*k].r     = alo[W-1:0];
			div_d[0].dv[2*k].b     = ad[W-1:0];
			div_d[0].dv[2*k].neg   = nlo[W] ^ d[W-1];
			div_d[0].dv[2*k+1].r   = ahi[W-1:0];
			div_d[0].dv[2*k+1].b   = ad[W-1:0];
			div_d[0].dv[2*k+1].neg = nhi[W] ^ d[W-1];
		end
	end

	// First divider stage: saturation test and integer quotient bit.
	always_comb begin
		div_d[1] = div_s[0];
		for (int j = 0; j < 6; j++) begin
			div_d[1].dv[j].sat = {1'b0, div_s[0].dv[j].r} >= {div_s[0].dv[j].b, 1'b0};
			if (div_s[0].dv[j].r >= div_s[0].dv[j].b) begin
				div_d[1].dv[j].q = (F+1)'(1);
				div_d[1].dv[j].r = div_s[0].dv[j].r - div_s[0].dv[j].b;
			end else begin
				div_d[1].dv[j].q = '0;
			end
		end
	end

	// Restoring division, one fraction bit per stage.
	for (genvar g = 1; g < ND - 1; g++) begin : g_step
		always_comb begin
			logic [W:0] rs;
			div_d[g+1] = div_s[g];
			for (int j = 0; j < 6; j++) begin
				rs = {div_s[g].dv[j].r, 1'b0};
				if (rs >= {1'b0, div_s[g].dv[j].b}) begin
					rs = rs - {1'b0, div_s[g].dv[j].b};
					div_d[g+1].dv[j].q = {div_s[g].dv[j].q[F-1:0], 1'b1};
				end else begin
					div_d[g+1].dv[j].q = {div_s[g].dv[j].q[F-1:0], 1'b0};
				end
				div_d[g+1].dv[j].r = rs[W-1:0];
			end
		end
	end

	// Signed slab times, ordered into entry and exit per axis.
	always_comb begin
		logic signed [TW-1:0] qv, t0, t1;
		t_d.org = div_s[ND-1].org;
		t_d.dir = div_s[ND-1].dir;
		t_d.ok  = div_s[ND-1].ok;
		t_d.ent = '0;
		t_d.ext = '0;
		for (int k = 0; k < 3; k++) begin
			qv = div_s[ND-1].dv[2*k].sat ? TLIM : TW'(div_s[ND-1].dv[2*k].q);
			t0 = div_s[ND-1].dv[2*k].neg ? -qv : qv;
			qv = div_s[ND-1].dv[2*k+1].sat ? TLIM : TW'(div_s[ND-1].dv[2*k+1].q);
			t1 = div_s[ND-1].dv[2*k+1].neg ? -qv : qv;
			if (div_s[ND-1].dz[k]) begin
				t_d.ent[k] = -TLIM;
				t_d.ext[k] = TLIM;
			end else if (t0 > t1) begin
				t_d.ent[k] = t1;
				t_d.ext[k] = t0;
			end else begin
				t_d.ent[k] = t0;
				t_d.ext[k] = t1;
			end
		end
	end

	// Latest entry, earliest exit, hit decision and entered axis.
	always_comb begin
		logic signed [TW-1:0] e0, e1, e2, tin, tout, x1, x2;
		e0 = t_s.ent[0];
		e1 = t_s.ent[1];
		e2 = t_s.ent[2];
		x1 = t_s.ext[1];
		x2 = t_s.ext[2];
		tin  = e0;
		tout = t_s.ext[0];
		if (e1 > tin) tin = e1;
		if (e2 > tin) tin = e2;
		if (x1 < tout) tout = x1;
		if (x2 < tout) tout = x2;
		r_d.org = t_s.org;
		r_d.dir = t_s.dir;
		r_d.hit = t_s.ok && !(tin > tout) && !(tin > ONE) && !(tin < 0);
		r_d.tin = r_d.hit ? tin[F:0] : ONE[F:0];
		priority if (e0 > e1 && e0 > e2)
			r_d.axis = 2'd0;
		else if (e1 > e0 && e1 > e2)
			r_d.axis = 2'd1;
		else
			r_d.axis = 2'd2;
	end

	// Face normal and scaled displacement magnitude per axis.
	always_comb begin
		logic signed [W-1:0] d;
		logic signed [W:0]   dw;
		logic [W:0]          ad;
		logic [W+F:0]        pr;
		m_d.hit = r_s.hit;
		m_d.tin = r_s.tin;
		m_d.org = r_s.org;
		for (int k = 0; k < 3; k++) begin
			d  = r_s.dir[k];
			dw = {d[W-1], d};
			ad = dw[W] ? -dw : dw;
			pr = ad[W-1:0] * r_s.tin;
			m_d.prod[k] = pr[W+F:F];
			m_d.dneg[k] = d[W-1];
			if (r_s.hit && r_s.axis == 2'(k))
				m_d.nrm[k] = (d > 0) ? NRM_NEG : NRM_POS;
			else
				m_d.nrm[k] = NRM_NONE;
		end
	end

	// Hit point: origin plus signed product, saturated.
	always_comb begin
		logic signed [W+1:0] v;
		logic signed [W+1:0] mx, mn;
		logic signed [W-1:0] o;
		mx = {3'b000, {(W-1){1'b1}}};
		mn = {3'b111, {(W-1){1'b0}}};
		pnt_d = '0;
		for (int k = 0; k < 3; k++) begin
			o = m_s.org[k];
			if (m_s.dneg[k])
				v = {{2{o[W-1]}}, o} - {1'b0, m_s.prod[k]};
			else
				v = {{2{o[W-1]}}, o} + {1'b0, m_s.prod[k]};
			if (v > mx) v = mx;
			if (v < mn) v = mn;
			pnt_d[k] = m_s.hit ? v[W-1:0] : '0;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s <= '0;
			t_vld_s   <= 1'b0;
			r_vld_s   <= 1'b0;
			m_vld_s   <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (ce) begin
			div_vld_s <= {div_vld_s[ND-2:0], s_axis_tvalid};
			t_vld_s   <= div_vld_s[ND-1];
			r_vld_s   <= t_vld_s;
			m_vld_s   <= r_vld_s;
			out_vld_q <= m_vld_s;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < ND; i++)
				div_s[i] <= div_d[i];
			t_s   <= t_d;
			r_s   <= r_d;
			m_s   <= m_d;
			hit_q <= m_s.hit;
			tin_q <= m_s.tin;
			nrm_q <= m_s.nrm;
			pnt_q <= pnt_d;
		end
	end

	// Output beat.
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = hit_q;
	assign m_axis_tdata  = OUT_W'({pnt_q[2], pnt_q[1], pnt_q[0],
		nrm_q[2], nrm_q[1], nrm_q[0], tin_q});

endmodule
